### rtl/core/pol_pkg.sv
`timescale 1ns / 1ps

package pol_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 5;
  localparam int KIND_W           = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_EXEC = 1'b1
  } phase_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic               capture;    // latch the compare result for a new item
    logic [VALUE_W-1:0] probe;      // value compared at capture
    logic               do_insert;  // open a gap and write ins_value
    logic               do_remove;  // close the gap at the first match
    logic [POS_W-1:0]   pos;        // 1-based insert position
    logic [VALUE_W-1:0] ins_value;
  } cell_cmd_t;

endpackage

### rtl/core/positional_ordered_list.sv
`timescale 1ns / 1ps

// ordered list of up to CAPACITY signed 32-bit entries held in a row of cells,
// one entry per cell. every item is one operation: insert at a 1-based
// position, remove the first entry equal to a value, find the first entry equal
// to a value, or clear. each item gives exactly one result carrying a status,
// the 1-based position of the match (remove and find) and the list length
// afterwards. an item has a compare and an execute phase: when it is accepted
// every cell compares its entry with the value, and in the execute phase a match
// flag ripples along the row, the cells shift towards or away from their
// neighbours in parallel and the result is registered. in_ready is low during
// the execute phase, so a new item is accepted only once the last one has
// executed. the result register holds while out_ready is low; a new item can
// be accepted during that wait but its execute phase waits for the register
// to free up. clear only zeroes the length, stale entries stay in the cells
// and are never read.

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_found_position,
  output logic [POS_W-1:0]           out_list_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // sequencer
  phase_t state_r;
  phase_t state_nxt;
  logic   accept;
  logic   exec;

  // current item
  kind_t              kind_r;
  logic [POS_W-1:0]   pos_r;
  logic [VALUE_W-1:0] value_r;

  // list length
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic                out_valid_r;
  logic                out_valid_nxt;
  status_t             status_r;
  status_t             status_nxt;
  logic [POS_W-1:0]    found_r;
  logic [POS_W-1:0]    found_nxt;
  logic [POS_W-1:0]    length_r;
  logic [POS_W-1:0]    length_nxt;

  // cell row
  cell_cmd_t          cmd;
  logic [CAPACITY:0]  seen;
  logic [CAPACITY-1:0] first_vec;
  logic [VALUE_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]   match_pos;
  logic               any_match;

  // insert position checks
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_bad;
  logic             list_full;
  logic             ins_ok;
  logic             rem_ok;

  assign in_ready  = (state_r == PH_IDLE);
  assign accept    = in_valid & in_ready;
  assign exec      = (state_r == PH_EXEC) & (~out_valid_r | out_ready);

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_list_length    = length_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_IDLE: begin
        if (accept) begin
          state_nxt = PH_EXEC;
        end
      end
      PH_EXEC: begin
        if (exec) begin
          state_nxt = PH_IDLE;
        end
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  // latch the item; payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_t'(in_kind);
      pos_r   <= in_position;
      value_r <= in_value;
    end
  end

  // position range and capacity checks for insert
  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign pos_bad   = (pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
  assign list_full = (count_r == CNT_W'(CAPACITY));
  assign any_match = seen[CAPACITY];
  assign ins_ok    = (kind_r == KIND_INSERT) && !pos_bad && !list_full;
  assign rem_ok    = (kind_r == KIND_REMOVE) && any_match;

  // broadcast to the cells: compare on accept, shift on execute
  always_comb begin
    cmd.capture   = accept;
    cmd.probe     = in_value;
    cmd.do_insert = exec & ins_ok;
    cmd.do_remove = exec & rem_ok;
    cmd.pos       = pos_r;
    cmd.ins_value = value_r;
  end

  assign seen[0] = 1'b0;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [VALUE_W-1:0] lower;
    logic [VALUE_W-1:0] upper;

    // row ends feed back their own entry; only the top one is used, on remove
    if (gi == 0) begin : g_lo_end
      assign lower = entries[gi];
    end else begin : g_lo
      assign lower = entries[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_hi_end
      assign upper = entries[gi];
    end else begin : g_hi
      assign upper = entries[gi+1];
    end

    pol_cell #(
      .INDEX (gi),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .lower_entry (lower),
      .upper_entry (upper),
      .seen_in     (seen[gi]),
      .seen_out    (seen[gi+1]),
      .first       (first_vec[gi]),
      .entry       (entries[gi])
    );
  end

  // one-hot first match to a 1-based position
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        match_pos = match_pos | CNT_W'(i + 1);
      end
    end
  end

  // operation outcome
  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = '0;
    count_nxt  = count_r;
    case (kind_r)
      KIND_INSERT: begin
        if (pos_bad) begin
          status_nxt = ST_BADPOS;
        end else if (list_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (any_match) begin
          found_nxt = POS_W'(match_pos);
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      KIND_FIND: begin
        if (any_match) begin
          found_nxt = POS_W'(match_pos);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    length_nxt = POS_W'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      length_r <= length_nxt;
    end
  end

  // checks

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_single_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_EXEC) |-> $onehot0(first_vec))
    else $error("more than one cell claims the first match");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_IDLE) |=> $stable(count_r))
    else $error("length changed without an item in execution");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == PH_EXEC))
    else $error("result appeared without an execute cycle");

endmodule

### rtl/core/pol_cell.sv
`timescale 1ns / 1ps

module pol_cell
  import pol_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]   count,
  input  logic [VALUE_W-1:0] lower_entry,
  input  logic [VALUE_W-1:0] upper_entry,
  input  logic               seen_in,
  output logic               seen_out,
  output logic               first,
  output logic [VALUE_W-1:0] entry
);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               eq_r;
  logic               eq_nxt;
  logic               live;

  assign live     = CNT_W'(INDEX) < count;
  assign seen_out = seen_in | eq_r;
  assign first    = eq_r & ~seen_in;
  assign entry    = entry_r;

  always_comb begin
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    if (cmd.capture) begin
      eq_nxt = live && (entry_r == cmd.probe);
    end
    if (cmd.do_insert) begin
      if ((INDEX + 1) == int'(cmd.pos)) begin
        entry_nxt = cmd.ins_value;
      end else if (INDEX >= int'(cmd.pos)) begin
        entry_nxt = lower_entry;
      end
    end else if (cmd.do_remove && seen_out) begin
      entry_nxt = upper_entry;
    end
  end

  always_ff @(posedge clk) begin
    eq_r    <= eq_nxt;
    entry_r <= entry_nxt;
  end

endmodule
